FILE: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Script token splitter package
// Shared constants, types and helpers for the token splitter blocks.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int MAX_TOKEN   = 1024;
  localparam int LEN_W       = $clog2(MAX_TOKEN);
  localparam int NSLOT       = 3;
  localparam int SLOT_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [5:0] {
    MODE_BETWEEN = 6'b000001,
    MODE_SLASH   = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_WORD    = 6'b001000,
    MODE_QUOTE   = 6'b010000,
    MODE_DONE    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       token_end;
    logic       data_end;
    logic       truncated;
  } item_t;

  typedef struct packed {
    item_t [NSLOT-1:0] items;
    logic [SLOT_W-1:0] count;
  } bundle_t;

  function automatic item_t char_item(logic [7:0] c);
    item_t it;
    it = '0;
    it.char_out = c;
    it.has_char = 1'b1;
    return it;
  endfunction

  function automatic item_t end_item(logic trunc);
    item_t it;
    it = '0;
    it.token_end = 1'b1;
    it.truncated = trunc;
    return it;
  endfunction

  function automatic item_t data_end_item();
    item_t it;
    it = '0;
    it.data_end = 1'b1;
    return it;
  endfunction

endpackage

FILE: rtl/sts_front.sv
// ----------------------------------------------------------------------------
// Token splitter front end
// Takes one byte per cycle while the queue has room, tracks the scan mode and
// turns the byte into a request of up to three result items for the queue.
// ----------------------------------------------------------------------------
module sts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  input  logic            begin_req,
  input  logic            q_ready,
  output logic            push,
  output sts_pkg::bundle_t push_bundle
);

  sts_pkg::mode_t                mode;
  logic [sts_pkg::LEN_W-1:0]     token_length;
  logic                          overflowed;

  sts_pkg::mode_t                mode_next;
  logic [sts_pkg::LEN_W-1:0]     token_length_next;
  logic                          overflowed_next;
  sts_pkg::bundle_t              bundle;
  logic                          accepted;

  always_comb begin
    logic do_word;
    logic do_between;
    logic is_sep;
    logic [sts_pkg::SLOT_W-1:0] n;
    mode_next         = mode;
    token_length_next = token_length;
    overflowed_next   = overflowed;
    bundle            = '0;
    n                 = '0;
    do_word           = 1'b0;
    do_between        = 1'b0;
    is_sep = (ch == sts_pkg::CH_TAB) || (ch == sts_pkg::CH_CR) ||
             (ch == sts_pkg::CH_LF) || (ch == sts_pkg::CH_SPACE);
    if (begin_req) begin
      mode_next         = sts_pkg::MODE_BETWEEN;
      token_length_next = '0;
      overflowed_next   = 1'b0;
    end
    unique case (mode_next)
      sts_pkg::MODE_BETWEEN: begin
        do_between = 1'b1;
      end
      sts_pkg::MODE_SLASH: begin
        if (ch == sts_pkg::CH_SLASH) begin
          mode_next = sts_pkg::MODE_COMMENT;
        end else begin
          mode_next         = sts_pkg::MODE_WORD;
          overflowed_next   = 1'b0;
          bundle.items[n]   = sts_pkg::char_item(sts_pkg::CH_SLASH);
          n                 = n + 2'd1;
          token_length_next = sts_pkg::LEN_W'(1);
          do_word           = 1'b1;
        end
      end
      sts_pkg::MODE_COMMENT: begin
        if (ch == sts_pkg::CH_NUL) begin
          bundle.items[n] = sts_pkg::data_end_item();
          n               = n + 2'd1;
          mode_next       = sts_pkg::MODE_DONE;
        end else if (ch == sts_pkg::CH_LF) begin
          mode_next = sts_pkg::MODE_BETWEEN;
        end
      end
      sts_pkg::MODE_WORD: begin
        do_word = 1'b1;
      end
      sts_pkg::MODE_QUOTE: begin
        if (ch == sts_pkg::CH_QUOTE || ch == sts_pkg::CH_NUL) begin
          bundle.items[n]   = sts_pkg::end_item(overflowed_next);
          n                 = n + 2'd1;
          token_length_next = '0;
          overflowed_next   = 1'b0;
          mode_next         = sts_pkg::MODE_BETWEEN;
          if (ch == sts_pkg::CH_NUL) begin
            bundle.items[n] = sts_pkg::data_end_item();
            n               = n + 2'd1;
            mode_next       = sts_pkg::MODE_DONE;
          end
        end else if (token_length_next < sts_pkg::LEN_W'(sts_pkg::MAX_TOKEN - 1)) begin
          bundle.items[n]   = sts_pkg::char_item(ch);
          n                 = n + 2'd1;
          token_length_next = token_length_next + sts_pkg::LEN_W'(1);
        end else begin
          overflowed_next = 1'b1;
        end
      end
      sts_pkg::MODE_DONE: begin
        mode_next = sts_pkg::MODE_DONE;
      end
      default: begin
        mode_next = sts_pkg::MODE_DONE;
      end
    endcase
    if (do_word) begin
      if (ch == sts_pkg::CH_NUL || is_sep) begin
        bundle.items[n]   = sts_pkg::end_item(overflowed_next);
        n                 = n + 2'd1;
        token_length_next = '0;
        overflowed_next   = 1'b0;
        mode_next         = sts_pkg::MODE_BETWEEN;
        do_between        = 1'b1;
      end else if (token_length_next < sts_pkg::LEN_W'(sts_pkg::MAX_TOKEN - 1)) begin
        bundle.items[n]   = sts_pkg::char_item(ch);
        n                 = n + 2'd1;
        token_length_next = token_length_next + sts_pkg::LEN_W'(1);
      end else begin
        overflowed_next = 1'b1;
      end
    end
    if (do_between) begin
      if (ch == sts_pkg::CH_NUL) begin
        bundle.items[n] = sts_pkg::data_end_item();
        n               = n + 2'd1;
        mode_next       = sts_pkg::MODE_DONE;
      end else if (ch == sts_pkg::CH_TAB || ch == sts_pkg::CH_LF ||
                   ch == sts_pkg::CH_SPACE) begin
        mode_next = sts_pkg::MODE_BETWEEN;
      end else if (ch == sts_pkg::CH_SLASH) begin
        mode_next = sts_pkg::MODE_SLASH;
      end else if (ch == sts_pkg::CH_QUOTE) begin
        token_length_next = '0;
        overflowed_next   = 1'b0;
        mode_next         = sts_pkg::MODE_QUOTE;
      end else begin
        mode_next         = sts_pkg::MODE_WORD;
        overflowed_next   = 1'b0;
        bundle.items[n]   = sts_pkg::char_item(ch);
        n                 = n + 2'd1;
        token_length_next = sts_pkg::LEN_W'(1);
      end
    end
    bundle.count = n;
  end

  assign in_ready    = q_ready;
  assign accepted    = in_valid && q_ready;
  assign push        = accepted && (bundle.count != '0);
  assign push_bundle = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sts_pkg::MODE_BETWEEN;
      token_length <= '0;
      overflowed   <= 1'b0;
    end else if (accepted) begin
      mode         <= mode_next;
      token_length <= token_length_next;
      overflowed   <= overflowed_next;
    end
  end

endmodule

FILE: rtl/sts_queue.sv
// ----------------------------------------------------------------------------
// Token splitter request queue
// Small first-in first-out buffer of item requests between front and back.
// ----------------------------------------------------------------------------
module sts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sts_pkg::bundle_t push_bundle,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output sts_pkg::bundle_t head
);

  sts_pkg::bundle_t               entries [sts_pkg::QUEUE_DEPTH];
  logic [sts_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sts_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sts_pkg::QCNT_W-1:0]     count;

  assign ready = (count != sts_pkg::QCNT_W'(sts_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sts_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sts_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sts_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sts_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> ready) else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("request popped from an empty queue");
`endif

endmodule

FILE: rtl/sts_back.sv
// ----------------------------------------------------------------------------
// Token splitter back end
// Walks the items of the queued request at the head and presents them one per
// cycle while the receiver is ready, through the output register.
// ----------------------------------------------------------------------------
module sts_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sts_pkg::bundle_t head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic [3:0]       m_tuser,
  output logic             m_tlast
);

  logic [sts_pkg::SLOT_W-1:0] idx;
  sts_pkg::item_t             cur;
  logic                       is_last;
  logic                       load;

  assign cur     = head.items[idx];
  assign is_last = (idx == (head.count - sts_pkg::SLOT_W'(1)));
  assign load    = q_valid && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= is_last ? '0 : idx + sts_pkg::SLOT_W'(1);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur.char_out;
      m_tuser <= {cur.truncated, cur.data_end, cur.token_end, cur.has_char};
      m_tlast <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser[2:0]))
    else $error("result item must be exactly one of byte, end marker, data end");
  a_trunc_on_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> m_tuser[1])
    else $error("truncated flag outside an end marker");
`endif

endmodule

FILE: rtl/script_token_splitter_core.sv
// ----------------------------------------------------------------------------
// Script token splitter core
// Splits a text byte stream into tokens of bytes, each closed by an end marker.
//
// The slave channel takes one text byte per request in s_tdata; s_tuser[0]
// restarts scanning for a new buffer. The master channel returns result
// items: a token byte, an end marker (optionally flagged truncated) or the
// end-of-data item, with m_tlast on the final item caused by one input byte.
// A byte yields zero to three items. The front end takes one byte per cycle
// while the four-entry request queue has room; the back end drains one item
// per cycle while the receiver is ready. The first item of a byte is written
// into a queue entry and then captured in the output register before it is
// presented on m_tvalid. Reset clears the scan mode to between tokens and
// empties the queue and the output register. When the receiver stalls, the
// output register holds its item, the queue fills, and s_tready falls once
// the queue is full.
// ----------------------------------------------------------------------------
module script_token_splitter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [0:0] s_tuser,   // [0] begin_req
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic [3:0] m_tuser,   // [0] has_char, [1] token_end, [2] data_end, [3] truncated
  output logic       m_tlast
);

  logic             q_ready;
  logic             push;
  sts_pkg::bundle_t push_bundle;
  logic             q_valid;
  logic             pop;
  sts_pkg::bundle_t head;

  sts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .ch          (s_tdata),
    .begin_req   (s_tuser[0]),
    .q_ready     (q_ready),
    .push        (push),
    .push_bundle (push_bundle)
  );

  sts_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .ready       (q_ready),
    .pop         (pop),
    .valid       (q_valid),
    .head        (head)
  );

  sts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/token_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token stream checker
// Watches both stream channels of the token splitter. Every accepted request
// byte is run through a local scanner that predicts the result items, and
// every accepted result item is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module token_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [0:0] s_tuser,   // [0] begin_req
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] char_out
  input  logic [3:0] m_tuser,   // [0] has_char, [1] token_end, [2] data_end, [3] truncated
  input  logic       m_tlast,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  typedef struct packed {
    sts_pkg::item_t item;
    logic           last;
  } result_t;

  sts_pkg::mode_t scan_mode;
  logic [10:0]    tok_len;
  logic           tok_dropped;
  sts_pkg::item_t step_items[$];
  result_t        awaited_items[$];

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    scan_mode = sts_pkg::MODE_BETWEEN;
    tok_len = '0;
    tok_dropped = 1'b0;
  end

  task automatic push_item(input logic [7:0] c, input logic hc, input logic te,
                           input logic de, input logic tr);
    sts_pkg::item_t it;
    it.char_out = c;
    it.has_char = hc;
    it.token_end = te;
    it.data_end = de;
    it.truncated = tr;
    step_items.push_back(it);
  endtask

  task automatic open_token();
    tok_len = '0;
    tok_dropped = 1'b0;
  endtask

  task automatic put_char(input logic [7:0] c);
    if (tok_len < sts_pkg::MAX_TOKEN - 1) begin
      push_item(c, 1'b1, 1'b0, 1'b0, 1'b0);
      tok_len = tok_len + 11'd1;
    end else begin
      tok_dropped = 1'b1;
    end
  endtask

  task automatic close_token();
    push_item(8'h00, 1'b0, 1'b1, 1'b0, tok_dropped);
    open_token();
    scan_mode = sts_pkg::MODE_BETWEEN;
  endtask

  task automatic end_data();
    push_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    scan_mode = sts_pkg::MODE_DONE;
  endtask

  task automatic between_byte(input logic [7:0] c);
    case (c) inside
      sts_pkg::CH_NUL: end_data();
      sts_pkg::CH_TAB, sts_pkg::CH_LF, sts_pkg::CH_SPACE: ;
      sts_pkg::CH_SLASH: scan_mode = sts_pkg::MODE_SLASH;
      sts_pkg::CH_QUOTE: begin
        open_token();
        scan_mode = sts_pkg::MODE_QUOTE;
      end
      default: begin
        open_token();
        scan_mode = sts_pkg::MODE_WORD;
        put_char(c);
      end
    endcase
  endtask

  task automatic word_byte(input logic [7:0] c);
    if (c == sts_pkg::CH_NUL || c == sts_pkg::CH_TAB || c == sts_pkg::CH_CR ||
        c == sts_pkg::CH_LF || c == sts_pkg::CH_SPACE) begin
      close_token();
      between_byte(c);
    end else begin
      put_char(c);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic restart);
    result_t r;
    step_items.delete();
    if (restart) begin
      scan_mode = sts_pkg::MODE_BETWEEN;
      open_token();
    end
    case (scan_mode)
      sts_pkg::MODE_BETWEEN: between_byte(c);
      sts_pkg::MODE_SLASH: begin
        if (c == sts_pkg::CH_SLASH) begin
          scan_mode = sts_pkg::MODE_COMMENT;
        end else begin
          open_token();
          scan_mode = sts_pkg::MODE_WORD;
          put_char(sts_pkg::CH_SLASH);
          word_byte(c);
        end
      end
      sts_pkg::MODE_COMMENT: begin
        if (c == sts_pkg::CH_NUL) begin
          end_data();
        end else if (c == sts_pkg::CH_LF) begin
          scan_mode = sts_pkg::MODE_BETWEEN;
        end
      end
      sts_pkg::MODE_WORD: word_byte(c);
      sts_pkg::MODE_QUOTE: begin
        if (c == sts_pkg::CH_QUOTE) begin
          close_token();
        end else if (c == sts_pkg::CH_NUL) begin
          close_token();
          end_data();
        end else begin
          put_char(c);
        end
      end
      default: scan_mode = sts_pkg::MODE_DONE;
    endcase
    foreach (step_items[i]) begin
      r.item = step_items[i];
      r.last = (i == step_items.size() - 1);
      awaited_items.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      scan_mode = sts_pkg::MODE_BETWEEN;
      open_token();
      awaited_items.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_items.size() == 0) begin
          $error("Result item with no request pending: data %0h, user %0h, last %0b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = awaited_items.pop_front();
          check_field("char_out", want.item.char_out, m_tdata);
          check_field("has_char", 8'(want.item.has_char), 8'(m_tuser[0]));
          check_field("token_end", 8'(want.item.token_end), 8'(m_tuser[1]));
          check_field("data_end", 8'(want.item.data_end), 8'(m_tuser[2]));
          check_field("truncated", 8'(want.item.truncated), 8'(m_tuser[3]));
          check_field("last", 8'(want.last), 8'(m_tlast));
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata, s_tuser[0]);
      end
    end
    pending <= awaited_items.size();
  end

endmodule

FILE: bench/script_token_splitter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script token splitter core testbench
// Feeds hand-written scripts, tokens at and past the length limit and random
// script fragments through the splitter, with bursty input and a stalling
// receiver, and lets the token stream checker judge every result item.
// ----------------------------------------------------------------------------
module script_token_splitter_core_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 350;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [0:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  int          fail_count;
  int          pending;
  int          checked;
  int          burst_left;
  int          live_bytes;
  int          total_bytes;
  logic        text_done;
  logic [31:0] cycles = '0;

  always #10 clk = ~clk;

  script_token_splitter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  token_stream_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // The receiver cycles through always ready, coin flips, sparse ready and a
  // fixed duty pattern, chosen by bits 9:8 of the cycle counter.
  always @(posedge clk) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    case (cycles[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(1, 0));
      2'd2: m_tready <= ($urandom_range(3, 0) == 0);
      default: m_tready <= (cycles[3:0] >= 4'd10);
    endcase
    cycles = cycles + 32'd1;
  end

  task automatic send_byte(input logic [7:0] c, input logic restart);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50)
                                               : $urandom_range(12, 1);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    total_bytes++;
    if (restart || !text_done) begin
      live_bytes++;
      text_done = (c == sts_pkg::CH_NUL);
    end
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_byte(txt[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(3, 0))
      0: return sts_pkg::CH_TAB;
      1: return sts_pkg::CH_LF;
      2: return sts_pkg::CH_CR;
      default: return sts_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] quote_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    return (c == sts_pkg::CH_QUOTE) ? 8'h21 : c;
  endfunction

  task automatic long_token(input int n, input logic quoted);
    if (quoted) begin
      send_byte(sts_pkg::CH_QUOTE, 1'b1);
      repeat (n) send_byte(quote_byte(), 1'b0);
      send_byte(sts_pkg::CH_QUOTE, 1'b0);
    end else begin
      send_byte(8'h4C, 1'b1);
      repeat (n - 1) send_byte(8'($urandom_range(126, 33)), 1'b0);
      send_byte(sts_pkg::CH_SPACE, 1'b0);
    end
  endtask

  task automatic random_fragment();
    int kind;
    int n;
    logic [7:0] c;
    kind = $urandom_range(99, 0);
    if (text_done) begin
      if ($urandom_range(3, 0) == 0) begin
        send_byte(8'($urandom_range(255, 0)), 1'b0);
      end else begin
        send_byte(($urandom_range(1, 0) == 0) ? pick_sep() : 8'h61, 1'b1);
      end
    end else if (kind < 30) begin
      n = $urandom_range(10, 1);
      repeat (n) send_byte(8'($urandom_range(126, 33)), 1'b0);
      send_byte(pick_sep(), 1'b0);
    end else if (kind < 45) begin
      n = $urandom_range(8, 0);
      send_byte(sts_pkg::CH_QUOTE, 1'b0);
      repeat (n) send_byte(quote_byte(), 1'b0);
      if ($urandom_range(9, 0) != 0) send_byte(sts_pkg::CH_QUOTE, 1'b0);
    end else if (kind < 55) begin
      n = $urandom_range(6, 0);
      send_text("//");
      repeat (n) begin
        c = 8'($urandom_range(255, 1));
        send_byte((c == sts_pkg::CH_LF) ? 8'h2A : c, 1'b0);
      end
      send_byte(sts_pkg::CH_LF, 1'b0);
    end else if (kind < 62) begin
      send_byte(sts_pkg::CH_SLASH, 1'b0);
      case ($urandom_range(3, 0))
        0: send_byte(8'h61, 1'b0);
        1: send_byte(sts_pkg::CH_CR, 1'b0);
        2: send_byte(sts_pkg::CH_QUOTE, 1'b0);
        default: send_byte(pick_sep(), 1'b0);
      endcase
    end else if (kind < 72) begin
      n = $urandom_range(4, 1);
      repeat (n) send_byte(pick_sep(), 1'b0);
    end else if (kind < 80) begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom_range(255, 128)), 1'b0);
      send_byte(pick_sep(), 1'b0);
    end else if (kind < 92) begin
      send_byte(8'($urandom_range(255, 0)), 1'b0);
    end else if (kind < 96) begin
      send_byte(sts_pkg::CH_NUL, 1'b0);
    end else begin
      send_byte(8'($urandom_range(255, 0)), 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    burst_left = 0;
    live_bytes = 0;
    total_bytes = 0;
    text_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Words, separators, quotes, a comment and lone slashes.
    send_byte(8'h41, 1'b1);
    send_text("b\t\r \"q z\"\"\"//c\n/x /\r ");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("\n/");
    send_byte(sts_pkg::CH_NUL, 1'b0);
    send_byte(sts_pkg::CH_NUL, 1'b0);
    send_byte(8'h41, 1'b0);
    // Unterminated quote, end of data inside a comment, abandoned token.
    send_byte(sts_pkg::CH_QUOTE, 1'b1);
    send_text("ab");
    send_byte(sts_pkg::CH_NUL, 1'b0);
    send_byte(sts_pkg::CH_SLASH, 1'b1);
    send_text("/x");
    send_byte(sts_pkg::CH_NUL, 1'b0);
    send_byte(8'h77, 1'b1);
    send_byte(8'h6B, 1'b1);
    send_byte(sts_pkg::CH_NUL, 1'b0);

    // Tokens right at, and just past, the length limit.
    long_token(sts_pkg::MAX_TOKEN - 1, 1'b0);
    long_token(sts_pkg::MAX_TOKEN, 1'b0);
    long_token(sts_pkg::MAX_TOKEN + 5, 1'b1);

    send_byte(8'h20, 1'b1);
    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) random_fragment();

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d text bytes, random phase and length-limit tokens included.",
             total_bytes);
    $display("Checked %0d result items against the predicted token stream.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sts_pkg.sv
rtl/sts_front.sv
rtl/sts_queue.sv
rtl/sts_back.sv
rtl/script_token_splitter_core.sv
bench/token_stream_checker.sv
bench/script_token_splitter_core_tb.sv
